// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the block pool allocator RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define FBPA_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("block pool allocator invariant violated");

// The antecedent at one edge implies the consequent at the next edge.
`define FBPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("block pool allocator sequence violated");

`endif

// ===== rtl/fbpa_pkg.sv =====
// Package for the fixed block pool allocator: sizes, codes, types and the
// block offset arithmetic. It depends on nothing else.
package fbpa_pkg;

  // Pool geometry.
  localparam int MAX_BLOCKS      = 64;
  localparam int IDX_W           = $clog2(MAX_BLOCKS);
  localparam int CNT_W           = IDX_W + 1;
  localparam int WORD_BYTES      = 8;
  localparam int WORD_SHIFT      = $clog2(WORD_BYTES);
  localparam int BLOCK_BYTES_CAP = 4096;

  // Field widths.
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int BB_W     = 13;
  localparam int OFF_W    = 18;
  localparam int PROD_W   = IDX_W + BB_W;

  // Configuration port.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic REG_BLOCK_BYTES   = 1'b0;
  localparam logic REG_BLOCKS_IN_USE = 1'b1;
  localparam logic [BB_W-1:0]  BLOCK_BYTES_RST   = BB_W'(8);
  localparam logic [CNT_W-1:0] BLOCKS_IN_USE_RST = CNT_W'(MAX_BLOCKS);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_REINIT = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

  // The head pointer holds this value when the free list is empty.
  localparam logic [CNT_W-1:0] HEAD_EMPTY = CNT_W'(MAX_BLOCKS);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Configuration as seen by the allocator core.
  typedef struct packed {
    logic [BB_W-1:0] block_bytes;
    cnt_t            pool_n;
    logic            reinit;
    cnt_t            reinit_n;
  } cfg_t;

  // Effective pool size: the register value saturated at MAX_BLOCKS.
  function automatic cnt_t pool_size(input cnt_t blocks);
    pool_size = (blocks > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : blocks;
  endfunction

  // Byte offset of a block's data: two header words, then one link word and
  // the word-aligned block size per block ahead of it.
  function automatic logic [OFF_W-1:0] data_offset(input idx_t idx,
                                                   input logic [BB_W-1:0] bb);
    logic [BB_W-1:0]   b;
    logic [BB_W-1:0]   aligned;
    logic [BB_W-1:0]   stride;
    logic [PROD_W-1:0] prod;
    b = (bb > BB_W'(BLOCK_BYTES_CAP)) ? BB_W'(BLOCK_BYTES_CAP) : bb;
    if (b < BB_W'(WORD_BYTES)) begin
      aligned = BB_W'(WORD_BYTES);
    end else begin
      aligned = ((b + BB_W'(WORD_BYTES - 1)) >> WORD_SHIFT) << WORD_SHIFT;
    end
    stride = aligned + BB_W'(WORD_BYTES);
    prod   = PROD_W'(idx) * PROD_W'(stride);
    data_offset = OFF_W'(prod + PROD_W'(2 * WORD_BYTES));
  endfunction

endpackage

// ===== rtl/fbpa_if.sv =====
// Valid/ready channel interfaces for allocator requests and results.
// Depends on fbpa_pkg for the field widths.
interface fbpa_req_if;
  logic                          valid;
  logic                          ready;
  logic [fbpa_pkg::OP_W-1:0]     op;
  fbpa_pkg::idx_t                free_index;

  modport source (output valid, op, free_index, input ready);
  modport sink (input valid, op, free_index, output ready);
endinterface

interface fbpa_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [fbpa_pkg::STATUS_W-1:0]     status;
  fbpa_pkg::idx_t                    block_index;
  logic [fbpa_pkg::OFF_W-1:0]        byte_offset;
  fbpa_pkg::cnt_t                    free_count;

  modport source (output valid, status, block_index, byte_offset, free_count,
                  input ready);
  modport sink (input valid, status, block_index, byte_offset, free_count,
                output ready);
endinterface

// ===== rtl/fbpa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next enabled read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/fbpa_cfg.sv =====
// APB-style configuration registers of the block pool allocator.
// Depends on fbpa_pkg; a write of the block count also flags a pool reinit.
module fbpa_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fbpa_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [fbpa_pkg::APB_DATA_W-1:0] pwdata,
  output logic [fbpa_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output fbpa_pkg::cfg_t                  cfg
);

  logic [fbpa_pkg::BB_W-1:0] block_bytes;
  fbpa_pkg::cnt_t            blocks_in_use;
  logic                      wr;
  fbpa_pkg::cnt_t            new_blocks;

  assign pready     = 1'b1;
  assign wr         = psel && penable && pwrite && pready;
  assign new_blocks = pwdata[fbpa_pkg::CNT_W-1:0];

  // Register writes; byte address bit 2 selects the register.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes   <= fbpa_pkg::BLOCK_BYTES_RST;
      blocks_in_use <= fbpa_pkg::BLOCKS_IN_USE_RST;
    end else if (wr) begin
      if (paddr[2] == fbpa_pkg::REG_BLOCK_BYTES) begin
        block_bytes <= pwdata[fbpa_pkg::BB_W-1:0];
      end else begin
        blocks_in_use <= new_blocks;
      end
    end
  end

  // Read back.
  assign prdata = (paddr[2] == fbpa_pkg::REG_BLOCK_BYTES) ?
                  fbpa_pkg::APB_DATA_W'(block_bytes) :
                  fbpa_pkg::APB_DATA_W'(blocks_in_use);

  // The pool reinitializes on the same edge as the block count write.
  assign cfg.block_bytes = block_bytes;
  assign cfg.pool_n      = fbpa_pkg::pool_size(blocks_in_use);
  assign cfg.reinit      = wr && (paddr[2] == fbpa_pkg::REG_BLOCKS_IN_USE);
  assign cfg.reinit_n    = fbpa_pkg::pool_size(new_blocks);

endmodule

// ===== rtl/fixed_block_pool_allocator_unit.sv =====
// A request transfer loads the input register and starts the registered read
// of the link memory at the list head; the result is registered once the
// result slot is free. A new request is taken only after the last completes.
// Reset (rst, synchronous) empties the free list, clears the untouched mark
// and sets the free count to the pool size; the link memory is not cleared.
`include "assert_macros.svh"

module fixed_block_pool_allocator_unit (
  input  logic                            clk,
  input  logic                            rst,
  fbpa_req_if.sink                        req,
  fbpa_rsp_if.source                      rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fbpa_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [fbpa_pkg::APB_DATA_W-1:0] pwdata,
  output logic [fbpa_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  fbpa_pkg::cfg_t cfg;

  // Request register.
  logic                          busy;
  logic [fbpa_pkg::OP_W-1:0]     op_q;
  fbpa_pkg::idx_t                fidx_q;
  logic                          accept;
  logic                          done;

  // Allocator state.
  fbpa_pkg::cnt_t list_head, list_head_next;
  fbpa_pkg::cnt_t mark, mark_next;
  fbpa_pkg::cnt_t free_total, free_total_next;
  fbpa_pkg::cnt_t link_rdata;
  logic           link_we;

  // Result register.
  logic                          out_valid;
  logic [fbpa_pkg::STATUS_W-1:0] status_q, status_next;
  fbpa_pkg::idx_t                index_q, index_next;
  logic [fbpa_pkg::OFF_W-1:0]    offset_q, offset_next;
  logic                          got;

  fbpa_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Successor links of the listed blocks.
  fbpa_ram #(
    .WIDTH (fbpa_pkg::CNT_W),
    .DEPTH (fbpa_pkg::MAX_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (fidx_q),
    .wdata (list_head),
    .re    (accept),
    .raddr (list_head[fbpa_pkg::IDX_W-1:0]),
    .rdata (link_rdata)
  );

  // Handshake: one request in flight; it completes once the result slot frees.
  assign req.ready = !busy;
  assign accept    = req.valid && req.ready;
  assign done      = busy && (!out_valid || rsp.ready);

  // Next state and result for the request held in the input register.
  always_comb begin
    list_head_next  = list_head;
    mark_next       = mark;
    free_total_next = free_total;
    status_next     = fbpa_pkg::ST_DONE;
    index_next      = '0;
    got             = 1'b0;
    link_we         = 1'b0;
    case (op_q)
      fbpa_pkg::OP_ALLOC: begin
        if (list_head < fbpa_pkg::HEAD_EMPTY) begin
          index_next     = list_head[fbpa_pkg::IDX_W-1:0];
          list_head_next = link_rdata;
          got            = 1'b1;
        end else if (mark < cfg.pool_n) begin
          index_next = mark[fbpa_pkg::IDX_W-1:0];
          mark_next  = mark + fbpa_pkg::CNT_W'(1);
          got        = 1'b1;
        end else begin
          status_next = fbpa_pkg::ST_FULL;
        end
        if (got && free_total != '0) begin
          free_total_next = free_total - fbpa_pkg::CNT_W'(1);
        end
      end
      fbpa_pkg::OP_FREE: begin
        if (fbpa_pkg::CNT_W'(fidx_q) >= cfg.pool_n) begin
          status_next = fbpa_pkg::ST_BAD_INDEX;
        end else begin
          // Push the block: its link takes the old head.
          link_we        = done;
          list_head_next = fbpa_pkg::CNT_W'(fidx_q);
          index_next     = fidx_q;
          got            = 1'b1;
          if (free_total < cfg.pool_n) begin
            free_total_next = free_total + fbpa_pkg::CNT_W'(1);
          end
        end
      end
      fbpa_pkg::OP_REINIT: begin
        list_head_next  = fbpa_pkg::HEAD_EMPTY;
        mark_next       = '0;
        free_total_next = cfg.pool_n;
      end
      default: begin
      end
    endcase
    offset_next = got ? fbpa_pkg::data_offset(index_next, cfg.block_bytes) : '0;
  end

  // Control and allocator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      out_valid  <= 1'b0;
      list_head  <= fbpa_pkg::HEAD_EMPTY;
      mark       <= '0;
      free_total <= fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS);
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      if (done) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.reinit) begin
        list_head  <= fbpa_pkg::HEAD_EMPTY;
        mark       <= '0;
        free_total <= cfg.reinit_n;
      end else if (done) begin
        list_head  <= list_head_next;
        mark       <= mark_next;
        free_total <= free_total_next;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= req.op;
      fidx_q <= req.free_index;
    end
    if (done) begin
      status_q <= status_next;
      index_q  <= index_next;
      offset_q <= offset_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = status_q;
  assign rsp.block_index = index_q;
  assign rsp.byte_offset = offset_q;
  assign rsp.free_count  = free_total;

  // The free count and the untouched mark never pass the pool size.
  `FBPA_ASSERT_ALWAYS(a_free_within_pool, free_total <= cfg.pool_n)
  `FBPA_ASSERT_ALWAYS(a_mark_within_pool, mark <= cfg.pool_n)
  // A request transfer drops ready in the following cycle.
  `FBPA_ASSERT_NEXT(a_one_in_flight, accept, !req.ready)
  // A completing request always leaves a result on the output.
  `FBPA_ASSERT_NEXT(a_done_gives_result, done, rsp.valid)

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for fixed_block_pool_allocator_unit.
// Uses fbpa_pkg and the request and reply interfaces from fbpa_if.sv; an
// in-bench free-list model predicts every reply and checks it in order.
module tb;

  // Op code 3 is not assigned by the block; it must leave the pool alone.
  localparam logic [fbpa_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 3000;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    logic [fbpa_pkg::OP_W-1:0] op;
    fbpa_pkg::idx_t            free_index;
  } pool_req_t;

  typedef struct packed {
    logic [fbpa_pkg::STATUS_W-1:0] status;
    fbpa_pkg::idx_t                block_index;
    logic [fbpa_pkg::OFF_W-1:0]    byte_offset;
    fbpa_pkg::cnt_t                free_count;
  } reply_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [fbpa_pkg::APB_ADDR_W-1:0] paddr;
  logic [fbpa_pkg::APB_DATA_W-1:0] pwdata;
  logic [fbpa_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  fbpa_req_if req();
  fbpa_rsp_if rsp();

  fixed_block_pool_allocator_unit dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Model state of the pool and its configuration.
  fbpa_pkg::cnt_t            link_mem [fbpa_pkg::MAX_BLOCKS];
  fbpa_pkg::cnt_t            head_block;
  fbpa_pkg::cnt_t            fresh_mark;
  fbpa_pkg::cnt_t            free_blocks;
  logic [fbpa_pkg::BB_W-1:0] cfg_block_bytes;
  fbpa_pkg::cnt_t            cfg_blocks;

  pool_req_t request_queue[$];
  reply_t    expected_replies[$];
  int        error_count = 0;
  int        quiet_cycles = 0;
  bit        req_accepted = 1'b0;

  // Idle controls: one-in-N chance of starting a burst, zero means none.
  int idle_odds = 0;
  int stall_odds = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_request = 0;
  int hold_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int pool_limit();
    return (cfg_blocks > fbpa_pkg::cnt_t'(fbpa_pkg::MAX_BLOCKS)) ?
           fbpa_pkg::MAX_BLOCKS : int'(cfg_blocks);
  endfunction

  function automatic void empty_pool_lists();
    head_block  = fbpa_pkg::HEAD_EMPTY;
    fresh_mark  = '0;
    free_blocks = fbpa_pkg::cnt_t'(pool_limit());
  endfunction

  // Data offset: two header words, then a link word plus the rounded block
  // size for every block ahead of this one.
  function automatic logic [fbpa_pkg::OFF_W-1:0] byte_offset_of(input fbpa_pkg::idx_t idx);
    int unsigned sz;
    sz = (cfg_block_bytes > fbpa_pkg::BLOCK_BYTES_CAP) ?
         fbpa_pkg::BLOCK_BYTES_CAP : cfg_block_bytes;
    if (sz < fbpa_pkg::WORD_BYTES) begin
      sz = fbpa_pkg::WORD_BYTES;
    end else begin
      sz = (sz + fbpa_pkg::WORD_BYTES - 1) / fbpa_pkg::WORD_BYTES * fbpa_pkg::WORD_BYTES;
    end
    return fbpa_pkg::OFF_W'(2 * fbpa_pkg::WORD_BYTES + idx * (fbpa_pkg::WORD_BYTES + sz));
  endfunction

  // Applies one request to the model and returns the reply it must give.
  function automatic reply_t predict_pool_op(input logic [fbpa_pkg::OP_W-1:0] op,
                                             input fbpa_pkg::idx_t fidx);
    reply_t r;
    int     n;
    int     idx;
    bit     got;
    r = '0;
    n = pool_limit();
    case (op)
      fbpa_pkg::OP_ALLOC: begin
        got = 1'b1;
        idx = 0;
        if (head_block < fbpa_pkg::HEAD_EMPTY) begin
          idx = head_block;
          head_block = link_mem[idx];
        end else if (fresh_mark < n) begin
          idx = fresh_mark;
          fresh_mark++;
        end else begin
          got = 1'b0;
        end
        if (got) begin
          if (free_blocks > 0) free_blocks--;
          r.block_index = fbpa_pkg::idx_t'(idx);
          r.byte_offset = byte_offset_of(fbpa_pkg::idx_t'(idx));
        end else begin
          r.status = fbpa_pkg::ST_FULL;
        end
      end
      fbpa_pkg::OP_FREE: begin
        if (fidx >= n) begin
          r.status = fbpa_pkg::ST_BAD_INDEX;
        end else begin
          // A double free is pushed again; the count saturates.
          link_mem[fidx] = head_block;
          head_block = fbpa_pkg::cnt_t'(fidx);
          if (free_blocks < n) free_blocks++;
          r.block_index = fidx;
          r.byte_offset = byte_offset_of(fidx);
        end
      end
      fbpa_pkg::OP_REINIT: empty_pool_lists();
      default: ;
    endcase
    r.free_count = free_blocks;
    return r;
  endfunction

  // Request driver: presents queued requests, with random idle bursts.
  always @(negedge clk) begin : request_driver
    pool_req_t item;
    if (!req.valid || req_accepted) begin
      if (send_gap > 0) begin
        send_gap--;
        req.valid <= 1'b0;
      end else if (request_queue.size() == 0) begin
        req.valid <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        send_gap = $urandom_range(0, 13);
        req.valid <= 1'b0;
      end else begin
        item = request_queue.pop_front();
        req.valid      <= 1'b1;
        req.op         <= item.op;
        req.free_index <= item.free_index;
      end
    end
  end

  // Reply receiver: random stall bursts, plus a long hold when requested.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request - 1;
      hold_request = 0;
      rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp.ready <= 1'b0;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      stall_left = $urandom_range(0, 13);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Monitor: check each reply transfer, then predict each request transfer.
  always @(posedge clk) begin : reply_check
    reply_t want;
    reply_t got;
    if (rsp.valid && rsp.ready) begin
      got = {rsp.status, rsp.block_index, rsp.byte_offset, rsp.free_count};
      if (expected_replies.size() == 0) begin
        report_mismatch("reply transfer with no request outstanding");
      end else begin
        want = expected_replies.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf(
            "status %0d index %0d offset %0d free %0d, expected %0d %0d %0d %0d",
            got.status, got.block_index, got.byte_offset, got.free_count,
            want.status, want.block_index, want.byte_offset, want.free_count));
        end
      end
    end
    req_accepted = req.valid && req.ready;
    if (req_accepted) begin
      expected_replies.push_back(predict_pool_op(req.op, req.free_index));
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void push_request(input logic [fbpa_pkg::OP_W-1:0] op, input int idx);
    pool_req_t item;
    item.op = op;
    item.free_index = fbpa_pkg::idx_t'(idx);
    request_queue.push_back(item);
  endfunction

  // Waits until every request is sent and every reply has come back.
  task automatic wait_drained();
    do @(posedge clk);
    while (request_queue.size() != 0 || req.valid || expected_replies.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // Writes a register, updates the model, then reads the register back.
  task automatic access_reg(input logic reg_sel,
                            input logic [fbpa_pkg::APB_DATA_W-1:0] value);
    logic [fbpa_pkg::APB_DATA_W-1:0] stored;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_sel == fbpa_pkg::REG_BLOCK_BYTES) begin
      cfg_block_bytes = value[fbpa_pkg::BB_W-1:0];
      stored = fbpa_pkg::APB_DATA_W'(cfg_block_bytes);
    end else begin
      cfg_blocks = value[fbpa_pkg::CNT_W-1:0];
      stored = fbpa_pkg::APB_DATA_W'(cfg_blocks);
      empty_pool_lists();
    end
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== stored) begin
      report_mismatch($sformatf("register read %0h, expected %0h", prdata, stored));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int n;
    int alloc_pct;
    int r;
    rst = 1'b1;
    req.valid = 1'b0;
    req.op = fbpa_pkg::OP_ALLOC;
    req.free_index = '0;
    rsp.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int i = 0; i < fbpa_pkg::MAX_BLOCKS; i++) link_mem[i] = '0;
    cfg_block_bytes = fbpa_pkg::BLOCK_BYTES_RST;
    cfg_blocks = fbpa_pkg::BLOCKS_IN_USE_RST;
    empty_pool_lists();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    idle_odds = 6;
    stall_odds = 6;

    // Reset configuration: fresh blocks, LIFO reuse, double free, odd ops.
    push_request(fbpa_pkg::OP_ALLOC, 0);
    push_request(fbpa_pkg::OP_ALLOC, 0);
    push_request(fbpa_pkg::OP_ALLOC, 0);
    push_request(fbpa_pkg::OP_FREE, 1);
    push_request(fbpa_pkg::OP_FREE, 2);
    push_request(fbpa_pkg::OP_ALLOC, 0);
    push_request(fbpa_pkg::OP_ALLOC, 0);
    push_request(fbpa_pkg::OP_ALLOC, 0);
    push_request(fbpa_pkg::OP_FREE, 63);
    push_request(fbpa_pkg::OP_FREE, 0);
    push_request(fbpa_pkg::OP_FREE, 0);
    push_request(OP_UNUSED, 63);
    push_request(fbpa_pkg::OP_REINIT, 0);
    push_request(fbpa_pkg::OP_ALLOC, 0);
    wait_drained();

    // Largest block in a two-block pool: full pool and bad free index.
    access_reg(fbpa_pkg::REG_BLOCK_BYTES, fbpa_pkg::BLOCK_BYTES_CAP);
    access_reg(fbpa_pkg::REG_BLOCKS_IN_USE, 2);
    push_request(fbpa_pkg::OP_ALLOC, 0);
    push_request(fbpa_pkg::OP_ALLOC, 0);
    push_request(fbpa_pkg::OP_ALLOC, 0);
    push_request(fbpa_pkg::OP_FREE, 1);
    push_request(fbpa_pkg::OP_FREE, 2);
    push_request(fbpa_pkg::OP_FREE, 63);
    push_request(fbpa_pkg::OP_ALLOC, 0);
    push_request(fbpa_pkg::OP_ALLOC, 0);
    wait_drained();

    // Empty pool.
    access_reg(fbpa_pkg::REG_BLOCKS_IN_USE, 0);
    push_request(fbpa_pkg::OP_ALLOC, 0);
    push_request(fbpa_pkg::OP_FREE, 0);
    wait_drained();

    // Random phases, each with its own configuration and mix.
    for (int phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(0, 5))
        0: access_reg(fbpa_pkg::REG_BLOCK_BYTES, 0);
        1: access_reg(fbpa_pkg::REG_BLOCK_BYTES, $urandom_range(1, 8));
        2: access_reg(fbpa_pkg::REG_BLOCK_BYTES, fbpa_pkg::BLOCK_BYTES_CAP);
        3: access_reg(fbpa_pkg::REG_BLOCK_BYTES, 8191);
        4: access_reg(fbpa_pkg::REG_BLOCK_BYTES,
                      $urandom_range(fbpa_pkg::BLOCK_BYTES_CAP + 1, 8191));
        default: access_reg(fbpa_pkg::REG_BLOCK_BYTES,
                            $urandom_range(1, fbpa_pkg::BLOCK_BYTES_CAP));
      endcase
      if (phase < 2 || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 7))
          0: access_reg(fbpa_pkg::REG_BLOCKS_IN_USE, 0);
          1: access_reg(fbpa_pkg::REG_BLOCKS_IN_USE, fbpa_pkg::MAX_BLOCKS);
          2: access_reg(fbpa_pkg::REG_BLOCKS_IN_USE, 127);
          3: access_reg(fbpa_pkg::REG_BLOCKS_IN_USE,
                        $urandom_range(fbpa_pkg::MAX_BLOCKS + 1, 126));
          default: access_reg(fbpa_pkg::REG_BLOCKS_IN_USE, $urandom_range(1, 8));
        endcase
      end
      n = pool_limit();
      alloc_pct = $urandom_range(30, 70);
      case ($urandom_range(0, 2))
        0: idle_odds = 0;
        1: idle_odds = 3;
        default: idle_odds = 8;
      endcase
      case ($urandom_range(0, 2))
        0: stall_odds = 0;
        1: stall_odds = 3;
        default: stall_odds = 8;
      endcase
      if (phase == 1) begin
        // Hold replies back while requests keep coming, so the block backs up.
        idle_odds = 0;
        hold_request = 60;
      end
      if (phase == PHASES - 1) begin
        idle_odds = 0;
        stall_odds = 0;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < alloc_pct) begin
          push_request(fbpa_pkg::OP_ALLOC, $urandom_range(0, 63));
        end else if (r < 92) begin
          push_request(fbpa_pkg::OP_FREE,
                       (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 63));
        end else if (r < 95) begin
          push_request(fbpa_pkg::OP_FREE, $urandom_range(0, 63));
        end else if (r < 98) begin
          push_request(fbpa_pkg::OP_REINIT, $urandom_range(0, 63));
        end else begin
          push_request(OP_UNUSED, $urandom_range(0, 63));
        end
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fbpa_pkg.sv
rtl/fbpa_if.sv
rtl/fbpa_ram.sv
rtl/fbpa_cfg.sv
rtl/fixed_block_pool_allocator_unit.sv
tb/tb.sv
